FILE: src/dsqrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsqrt_pkg
// Shared types, constants and the root step for the double square root unit.
// ----------------------------------------------------------------------------
package dsqrt_pkg;

  localparam int unsigned MantW = 54;   // scaled mantissa, after odd-exponent shift
  localparam int unsigned RemW  = 54;   // partial remainder, never above 2*root
  localparam int unsigned RootW = 53;   // final root width
  localparam int unsigned ExpW  = 13;   // signed unbiased exponent
  localparam int unsigned RootStages = 26;  // two root steps each

  localparam logic [10:0] ExpMax   = 11'h7FF;
  localparam logic [63:0] QnanBits = 64'h7FF8_0000_0000_0000;
  localparam logic signed [ExpW-1:0] ExpBias = 13'sd1075;

  typedef struct packed {
    logic                     special;
    logic [63:0]              spec_bits;
    logic [MantW-1:0]         m;
    logic [RemW-1:0]          rem;
    logic [RootW-1:0]         root;
    logic signed [ExpW-1:0]   e;
  } stage_t;

  // One digit of the integer root: take the next two mantissa bits.
  function automatic stage_t root_step(input stage_t s);
    stage_t      r;
    logic [55:0] rem2;
    logic [55:0] trial;
    r     = s;
    rem2  = {s.rem, s.m[MantW-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    r.m   = {s.m[MantW-3:0], 2'b00};
    if (rem2 >= trial) begin
      r.rem  = RemW'(rem2 - trial);
      r.root = {s.root[RootW-2:0], 1'b1};
    end else begin
      r.rem  = RemW'(rem2);
      r.root = {s.root[RootW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: src/dsqrt_root_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsqrt_root_stage
// One register stage of the root pipeline: two root digits per stage.
// ----------------------------------------------------------------------------
module dsqrt_root_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             prev_vld,
  input  dsqrt_pkg::stage_t prev_data,
  output logic             vld,
  output dsqrt_pkg::stage_t data
);

  dsqrt_pkg::stage_t data_next;

  always_comb begin
    data_next = dsqrt_pkg::root_step(dsqrt_pkg::root_step(prev_data));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= prev_vld;
    end
  end

  // hold payload while stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      data <= data_next;
    end
  end

endmodule

FILE: src/double_square_root_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_square_root_unit
// IEEE 754 double square root, round to nearest even, on raw bit patterns.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: operand_bits with in_valid / in_stall. An item is taken
//   at a clock edge with in_valid high and in_stall low.
//   Output channel: result_bits with out_valid / out_stall, one result per
//   item, in order.
//   Throughput: one item per cycle while the output is not stalled.
//   Pipeline: 29 register stages from accept to out_valid: decode and
//   leading-zero count (loaded at the accepting edge), normalize plus the
//   first root digit, 26 stages of two root digits each (the 53-digit
//   root sets the depth), then round and pack.
//   Reset clears every stage valid bit; the pipeline comes up empty.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_stall rises; nothing is dropped or repeated.
//   Special operands (zeros, +inf, NaN, negatives) ride the pipeline with
//   their answer already formed.
// ----------------------------------------------------------------------------
module double_square_root_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] operand_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_bits
);

  localparam int unsigned NStg = dsqrt_pkg::RootStages;

  logic adv;

  // Stage A: decode
  logic        a_vld;
  logic        a_special;
  logic [63:0] a_spec_bits;
  logic [51:0] a_frac;
  logic [10:0] a_ef;
  logic [5:0]  a_shift;

  logic        a_special_next;
  logic [63:0] a_spec_bits_next;
  logic [5:0]  a_shift_next;

  // Stage B: normalized, first digit done
  logic              b_vld;
  dsqrt_pkg::stage_t b_data;
  dsqrt_pkg::stage_t b_data_next;

  logic              stg_vld  [NStg+1];
  dsqrt_pkg::stage_t stg_data [NStg+1];

  logic [63:0] result_next;

  // Advance everything unless a finished result is being held.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Special cases and leading-zero count for subnormals.
  always_comb begin
    logic [10:0] ef;
    logic [51:0] frac;
    ef   = operand_bits[62:52];
    frac = operand_bits[51:0];
    a_special_next   = 1'b0;
    a_spec_bits_next = operand_bits;
    if (operand_bits[62:0] == 63'd0) begin
      a_special_next = 1'b1;
    end else if (ef == dsqrt_pkg::ExpMax) begin
      a_special_next = 1'b1;
      if (frac == 52'd0 && operand_bits[63]) begin
        a_spec_bits_next = dsqrt_pkg::QnanBits;
      end
    end else if (operand_bits[63]) begin
      a_special_next   = 1'b1;
      a_spec_bits_next = dsqrt_pkg::QnanBits;
    end
    // shift that brings the top set bit of frac to bit 52
    a_shift_next = 6'd0;
    if (ef == 11'd0) begin
      for (int k = 0; k < 52; k++) begin
        if (frac[k]) begin
          a_shift_next = 6'(52 - k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_special   <= a_special_next;
      a_spec_bits <= a_spec_bits_next;
      a_frac      <= operand_bits[51:0];
      a_ef        <= operand_bits[62:52];
      a_shift     <= a_shift_next;
    end
  end

  // Normalize, make the exponent even, take the first root digit.
  always_comb begin
    logic [52:0]                    m53;
    logic signed [dsqrt_pkg::ExpW-1:0] e;
    dsqrt_pkg::stage_t              s;
    if (a_ef == 11'd0) begin
      m53 = {1'b0, a_frac} << a_shift;
      e   = 13'sd1 - dsqrt_pkg::ExpBias - $signed({7'd0, a_shift});
    end else begin
      m53 = {1'b1, a_frac};
      e   = $signed({2'b00, a_ef}) - dsqrt_pkg::ExpBias;
    end
    s.special   = a_special;
    s.spec_bits = a_spec_bits;
    s.rem       = '0;
    s.root      = '0;
    if (e[0]) begin
      s.m = {m53, 1'b0};
      s.e = e - 13'sd1;
    end else begin
      s.m = {1'b0, m53};
      s.e = e;
    end
    b_data_next = dsqrt_pkg::root_step(s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_data <= b_data_next;
    end
  end

  assign stg_vld[0]  = b_vld;
  assign stg_data[0] = b_data;

  // Root pipeline: 26 stages, two digits each.
  for (genvar g = 0; g < NStg; g++) begin : g_root
    dsqrt_root_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .prev_vld  (stg_vld[g]),
      .prev_data (stg_data[g]),
      .vld       (stg_vld[g+1]),
      .data      (stg_data[g+1])
    );
  end

  // Round to nearest and pack.
  always_comb begin
    dsqrt_pkg::stage_t                 s;
    logic [dsqrt_pkg::RootW:0]         r;
    logic signed [dsqrt_pkg::ExpW-1:0] rexp;
    logic signed [dsqrt_pkg::ExpW-1:0] ebias;
    s    = stg_data[NStg];
    rexp = (s.e - 13'sd52) >>> 1;
    if (s.rem > {1'b0, s.root}) begin
      r = {1'b0, s.root} + 54'd1;
    end else begin
      r = {1'b0, s.root};
    end
    if (r[dsqrt_pkg::RootW]) begin
      r    = r >> 1;
      rexp = rexp + 13'sd1;
    end
    ebias = rexp + dsqrt_pkg::ExpBias;
    if (s.special) begin
      result_next = s.spec_bits;
    end else begin
      result_next = {1'b0, ebias[10:0], r[51:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= stg_vld[NStg];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_bits <= result_next;
    end
  end

  // A root is zero, normal, infinite or NaN: never subnormal.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result_bits[62:52] != 11'd0 || result_bits[62:0] == 63'd0))
    else $error("subnormal square root result");

  // Only -0 or a NaN may carry the sign bit.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_bits[63]) |->
      (result_bits[62:0] == 63'd0 || result_bits[62:52] == dsqrt_pkg::ExpMax))
    else $error("negative square root result");

  // A held pipeline keeps the valid bits of stages A and B unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(a_vld) && $stable(b_vld)))
    else $error("pipeline moved while stalled");

endmodule
